FILE: design/depth_min_max_jet_colormap_top_defines.svh
// ---------------------------------------------------------------------------
// Depth min/max jet colormap assertion macros
// Shared concurrent assertion forms used by the colormap modules.
// ---------------------------------------------------------------------------
`ifndef DEPTH_MIN_MAX_JET_COLORMAP_TOP_DEFINES_SVH
`define DEPTH_MIN_MAX_JET_COLORMAP_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dmm_pkg.sv
// ---------------------------------------------------------------------------
// Depth min/max jet colormap package
// Operation codes, fixed-point constants, shared types and palette functions.
// ---------------------------------------------------------------------------
package dmm_pkg;

	localparam int OP_W    = 2;
	localparam int DEPTH_W = 32;
	localparam int T_W     = 17;
	localparam int QUO_W   = 16;
	localparam int SPAN_W  = 31;

	localparam logic [OP_W-1:0] OP_START   = 2'd0;
	localparam logic [OP_W-1:0] OP_FOLD    = 2'd1;
	localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

	localparam logic signed [DEPTH_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
	localparam logic signed [DEPTH_W-1:0] MAX_RESET = 32'sh8000_0000;

	localparam logic [T_W-1:0] ONE_Q16          = 17'd65536;
	localparam logic [17:0]    QUARTER_Q16      = 18'd16384;
	localparam logic [17:0]    THREE_QUARTER_Q16 = 18'd49152;
	localparam logic signed [17:0] HALF_Q16     = 18'sd32768;

	typedef struct packed {
		logic              start;
		logic [SPAN_W-1:0] num;
		logic [SPAN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	function automatic logic [T_W-1:0] tent(input logic signed [17:0] x);
		logic [17:0] u;
		logic [18:0] slope;
		u = x[17] ? 18'(-x) : 18'(x);
		slope = {THREE_QUARTER_Q16 - u, 1'b0};
		if (u <= QUARTER_Q16) begin
			return ONE_Q16;
		end else if (u >= THREE_QUARTER_Q16) begin
			return '0;
		end else begin
			return slope[T_W-1:0];
		end
	endfunction

	function automatic logic [7:0] to_byte(input logic [T_W-1:0] v);
		logic [24:0] p;
		p = {v, 8'b0} - {8'b0, v};
		return p[23:16];
	endfunction

endpackage

FILE: design/dmm_sample_if.sv
// ---------------------------------------------------------------------------
// Depth sample channel
// Valid/ready channel carrying an operation code and a Q16.16 depth sample.
// ---------------------------------------------------------------------------
interface dmm_sample_if;
	logic                              valid;
	logic                              ready;
	logic [dmm_pkg::OP_W-1:0]          op;
	logic signed [dmm_pkg::DEPTH_W-1:0] depth;

	modport source (output valid, op, depth, input ready);
	modport sink   (input valid, op, depth, output ready);
endinterface

FILE: design/dmm_pixel_if.sv
// ---------------------------------------------------------------------------
// Colormapped pixel channel
// Valid/ready channel carrying one RGBA pixel.
// ---------------------------------------------------------------------------
interface dmm_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: design/dmm_div.sv
// ---------------------------------------------------------------------------
// Depth min/max jet colormap serial divider
// Restoring divider producing one quotient bit per cycle for a Q0.16 ratio.
// ---------------------------------------------------------------------------
`include "depth_min_max_jet_colormap_top_defines.svh"

module dmm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dmm_pkg::div_req_t req,
	output dmm_pkg::div_rsp_t rsp
);
	import dmm_pkg::*;

	logic [SPAN_W:0]  rem_q;
	logic [SPAN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SPAN_W:0]  shifted;
	logic             fits;

	assign shifted = {rem_q[SPAN_W-1:0], 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= {1'b0, req.num};
				den_q  <= req.den;
				cnt_q  <= 5'(QUO_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
				quo_q <= {quo_q[QUO_W-2:0], fits};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	`DMM_ASSERT_NOW(a_busy_count, busy_q, cnt_q != 5'd0, "divider busy with zero count")
	`DMM_ASSERT_NOW(a_done_idle, done_q, !busy_q, "divider done while still busy")
	`DMM_ASSERT_NEXT(a_start_busy, req.start, busy_q && cnt_q == 5'(QUO_W),
		"divider did not start")
endmodule

FILE: design/dmm_jet.sv
// ---------------------------------------------------------------------------
// Depth min/max jet colormap palette
// Maps a Q1.16 normalized depth to a jet RGBA pixel through tent functions.
// ---------------------------------------------------------------------------
module dmm_jet (
	input  logic [dmm_pkg::T_W-1:0] t,
	output dmm_pkg::pix_t           pix
);
	import dmm_pkg::*;

	logic signed [17:0] ts;

	assign ts        = $signed({1'b0, t});
	assign pix.red   = to_byte(tent(ts - HALF_Q16));
	assign pix.green = to_byte(tent(ts));
	assign pix.blue  = to_byte(tent(ts + HALF_Q16));
	assign pix.alpha = 8'hFF;
endmodule

FILE: design/depth_min_max_jet_colormap_top.sv
// ---------------------------------------------------------------------------
// Depth min/max jet colormap
// Tracks the depth range of a frame and maps each convert sample to a jet color.
// ---------------------------------------------------------------------------
// Channel  Role    Payload
// sample   sink    op (2 bits), depth (signed Q16.16)
// pixel    source  red, green, blue, alpha (8 bits each)
//
// A convert request passes through capture, a range check, 16 divider steps,
// taking the quotient and loading the output register.
// Out-of-range, invalid or flat-frame samples skip the divider.
// Reset sets the minimum to the largest and the maximum to the most negative value.
// A waiting pixel stalls the loading of the next pixel and so new samples.
// ---------------------------------------------------------------------------
`include "depth_min_max_jet_colormap_top_defines.svh"

module depth_min_max_jet_colormap_top (
	input logic        clk,
	input logic        arst_n,
	dmm_sample_if.sink sample,
	dmm_pixel_if.source pixel
);
	import dmm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]                st_q;
	logic signed [DEPTH_W-1:0] min_q;
	logic signed [DEPTH_W-1:0] max_q;
	logic signed [DEPTH_W-1:0] d_q;
	logic [T_W-1:0]            t_q;
	logic                      zero_q;
	pix_t                      pix_q;
	logic                      pix_valid_q;

	logic signed [DEPTH_W:0] diff;
	logic signed [DEPTH_W:0] span;
	logic                    in_range;
	logic                    pix_load;
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	pix_t                    jet_pix;

	assign diff     = $signed({d_q[DEPTH_W-1], d_q}) - $signed({min_q[DEPTH_W-1], min_q});
	assign span     = $signed({max_q[DEPTH_W-1], max_q}) - $signed({min_q[DEPTH_W-1], min_q});
	assign in_range = (d_q > 32'sd0) && (max_q > min_q);
	assign pix_load = (st_q == ST_RES) && (!pix_valid_q || pixel.ready);

	assign div_req.start = (st_q == ST_PREP) && in_range && (diff > 33'sd0) && (diff < span);
	assign div_req.num   = diff[SPAN_W-1:0];
	assign div_req.den   = span[SPAN_W-1:0];

	dmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dmm_jet u_jet (
		.t   (t_q),
		.pix (jet_pix)
	);

	assign sample.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			pix_valid_q <= 1'b0;
		end else begin
			if (pixel.ready && !pix_load) begin
				pix_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (sample.valid) begin
						case (sample.op)
							OP_START: begin
								min_q <= MIN_RESET;
								max_q <= MAX_RESET;
							end
							OP_FOLD: begin
								if (sample.depth > 32'sd0) begin
									if (sample.depth < min_q) begin
										min_q <= sample.depth;
									end
									if (sample.depth > max_q) begin
										max_q <= sample.depth;
									end
								end
							end
							OP_CONVERT: begin
								d_q  <= sample.depth;
								st_q <= ST_PREP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PREP: begin
					zero_q <= !in_range;
					if (!in_range) begin
						st_q <= ST_RES;
					end else if (diff <= 33'sd0) begin
						t_q  <= '0;
						st_q <= ST_RES;
					end else if (diff >= span) begin
						t_q  <= ONE_Q16;
						st_q <= ST_RES;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						t_q  <= {1'b0, div_rsp.quo};
						st_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (pix_load) begin
						pix_q       <= zero_q ? '0 : jet_pix;
						pix_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pixel.valid = pix_valid_q;
	assign pixel.red   = pix_q.red;
	assign pixel.green = pix_q.green;
	assign pixel.blue  = pix_q.blue;
	assign pixel.alpha = pix_q.alpha;

	`DMM_ASSERT_NOW(a_ready_div_idle, sample.ready, !div_rsp.busy,
		"sample accepted while divider busy")
	`DMM_ASSERT_NOW(a_start_free, div_req.start, !div_rsp.busy,
		"divider started while busy")
	`DMM_ASSERT_NEXT(a_done_result, (st_q == ST_DIV) && div_rsp.done, st_q == ST_RES,
		"quotient not taken to result")
	`DMM_ASSERT_NOW(a_blank_pixel, pixel.valid && (pixel.alpha == 8'd0),
		(pixel.red == 8'd0) && (pixel.green == 8'd0) && (pixel.blue == 8'd0),
		"blank pixel carries color")
endmodule

FILE: bench/dmm_colormap_checker.sv
// ---------------------------------------------------------------------------
// Depth jet colormap checker
// Watches the sample and pixel channels, keeps its own copy of the frame
// range, predicts the pixel for every accepted convert request and compares
// each delivered pixel field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module dmm_colormap_checker
	import dmm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	dmm_sample_if sample,
	dmm_pixel_if  pixel,
	output int    fail_count,
	output int    pending,
	output int    pixels_checked,
	output int    blank_pixels
);

	logic signed [DEPTH_W-1:0] frame_min;
	logic signed [DEPTH_W-1:0] frame_max;
	pix_t                      expected_pixels[$];

	function automatic int jet_tent(input int x);
		int u;
		u = (x < 0) ? -x : x;
		if (u <= 16384) begin
			return 65536;
		end else if (u >= 49152) begin
			return 0;
		end
		return 2 * (49152 - u);
	endfunction

	function automatic logic [7:0] scale_to_byte(input int v);
		return 8'((v * 255) >>> 16);
	endfunction

	function automatic pix_t jet_pixel(input logic signed [DEPTH_W-1:0] d,
			input logic signed [DEPTH_W-1:0] lo, input logic signed [DEPTH_W-1:0] hi);
		longint span;
		longint diff;
		int     t;
		pix_t   px;
		px = '0;
		if (d <= 0 || hi <= lo) begin
			return px;
		end
		span = longint'(hi) - longint'(lo);
		diff = longint'(d) - longint'(lo);
		if (diff <= 0) begin
			t = 0;
		end else if (diff >= span) begin
			t = 65536;
		end else begin
			t = int'((diff << 16) / span);
		end
		px.red   = scale_to_byte(jet_tent(t - 32768));
		px.green = scale_to_byte(jet_tent(t));
		px.blue  = scale_to_byte(jet_tent(t + 32768));
		px.alpha = 8'd255;
		return px;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		if (!arst_n) begin
			frame_min      <= MIN_RESET;
			frame_max      <= MAX_RESET;
			expected_pixels.delete();
			fail_count     = 0;
			pixels_checked = 0;
			blank_pixels   = 0;
			pending        <= 0;
		end else begin
			// A pixel can never belong to a request accepted at the same edge.
			if (pixel.valid && pixel.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel %0d/%0d/%0d/%0d arrived with no request waiting",
						pixel.red, pixel.green, pixel.blue, pixel.alpha);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					compare_field("red", want.red, pixel.red);
					compare_field("green", want.green, pixel.green);
					compare_field("blue", want.blue, pixel.blue);
					compare_field("alpha", want.alpha, pixel.alpha);
					pixels_checked++;
					if (want.alpha == 8'd0) begin
						blank_pixels++;
					end
				end
			end
			if (sample.valid && sample.ready) begin
				case (sample.op)
					OP_START: begin
						frame_min <= MIN_RESET;
						frame_max <= MAX_RESET;
					end
					OP_FOLD: begin
						if (sample.depth > 0) begin
							if (sample.depth < frame_min) begin
								frame_min <= sample.depth;
							end
							if (sample.depth > frame_max) begin
								frame_max <= sample.depth;
							end
						end
					end
					OP_CONVERT: begin
						expected_pixels.push_back(jet_pixel(sample.depth, frame_min, frame_max));
					end
					default: begin
					end
				endcase
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

FILE: bench/tb_depth_min_max_jet_colormap_top.sv
// ---------------------------------------------------------------------------
// Depth jet colormap testbench
// Streams frames of start, accumulate and convert requests into the block,
// with random gaps on both channels and one long output hold-off, and lets
// the checker compare every pixel against its own prediction.
// ---------------------------------------------------------------------------
module tb_depth_min_max_jet_colormap_top;
	import dmm_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET  = 650;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 3000;

	logic clk;
	logic arst_n;
	bit   idle_on;
	bit   hold_request;
	int   requests_sent;
	int   frames_played;
	int   fail_count;
	int   pending;
	int   pixels_checked;
	int   blank_pixels;
	int   idle_cycles;

	dmm_sample_if sample_ch ();
	dmm_pixel_if  pixel_ch ();

	depth_min_max_jet_colormap_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.pixel  (pixel_ch)
	);

	dmm_colormap_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample_ch),
		.pixel          (pixel_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.pixels_checked (pixels_checked),
		.blank_pixels   (blank_pixels)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no request or pixel moved for %0d cycles.", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (!idle_on || pick < 60) begin
			return 0;
		end else if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [DEPTH_W-1:0] non_positive_depth();
		logic [DEPTH_W-1:0] r;
		r = $urandom();
		r[DEPTH_W-1] = 1'b1;
		return ($urandom_range(0, 3) == 0) ? '0 : r;
	endfunction

	initial begin : receiver
		int stall;
		bit hold_done;
		stall = 0;
		hold_done = 1'b0;
		pixel_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				pixel_ch.ready <= 1'b0;
				stall--;
			end else begin
				pixel_ch.ready <= 1'b1;
				stall = idle_gap();
			end
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op,
			input logic signed [DEPTH_W-1:0] depth);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.op    <= op;
		sample_ch.depth <= depth;
		do @(posedge clk); while (!sample_ch.ready);
		if (op != OP_UNUSED) begin
			requests_sent++;
		end
	endtask

	task automatic play_frame();
		int unsigned lo;
		int unsigned hi;
		int unsigned span;
		int          folds;
		int          converts;
		int          pick;
		bit          low_first;
		case ($urandom_range(0, 3))
			0: begin
				lo   = $urandom_range(1, 1000);
				span = $urandom_range(1, 200);
			end
			1: begin
				lo   = $urandom_range(1, 32'h00FF_FFFF);
				span = $urandom_range(1, 32'h0010_0000);
			end
			2: begin
				lo   = $urandom_range(1, 32'h3FFF_FFFF);
				span = $urandom_range(1, 32'h3FFF_FFFF);
			end
			default: begin
				lo   = $urandom_range(1, 16);
				span = 32'h7FFF_FFFF - lo;
			end
		endcase
		hi = lo + span;
		low_first = $urandom_range(0, 1);
		frames_played++;
		send_request(OP_START, $urandom());
		// A single accumulate leaves a flat frame.
		folds = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
		for (int i = 0; i < folds; i++) begin
			pick = $urandom_range(0, 9);
			if (i == 0) begin
				send_request(OP_FOLD, low_first ? lo : hi);
			end else if (i == 1) begin
				send_request(OP_FOLD, low_first ? hi : lo);
			end else if (pick == 0) begin
				send_request(OP_FOLD, non_positive_depth());
			end else begin
				send_request(OP_FOLD, $urandom_range(hi, lo));
			end
		end
		converts = $urandom_range(1, 10);
		for (int i = 0; i < converts; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_request(OP_CONVERT, $urandom_range(hi, lo));
			end else if (pick < 75) begin
				send_request(OP_CONVERT, $urandom_range(lo, 1));
			end else if (pick < 80) begin
				send_request(OP_CONVERT, $urandom_range(32'h7FFF_FFFF, hi));
			end else if (pick < 90) begin
				send_request(OP_CONVERT, non_positive_depth());
			end else begin
				send_request(OP_CONVERT, $urandom());
			end
		end
	endtask

	task automatic noise_burst();
		int count;
		count = $urandom_range(1, 6);
		repeat (count) begin
			send_request(OP_W'($urandom_range(0, 3)), $urandom());
		end
	endtask

	// Back-to-back converts against a stopped output so the block backs up.
	task automatic long_hold_burst();
		idle_on = 1'b0;
		send_request(OP_START, 0);
		send_request(OP_FOLD, 100);
		send_request(OP_FOLD, 5000000);
		hold_request = 1'b1;
		repeat (12) begin
			send_request(OP_CONVERT, $urandom_range(5000000, 100));
		end
	endtask

	initial begin : stimulus
		int round;
		arst_n          <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.op    <= OP_START;
		sample_ch.depth <= '0;
		idle_on       = 1'b0;
		hold_request  = 1'b0;
		requests_sent = 0;
		frames_played = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Convert before any start, an unused code, and an empty frame.
		send_request(OP_CONVERT, 100);
		send_request(OP_UNUSED, 5);
		send_request(OP_START, 0);
		send_request(OP_CONVERT, 1);
		// Extreme samples, with non-positive and unused-code requests ignored.
		send_request(OP_START, 32'h8000_0000);
		send_request(OP_FOLD, 1);
		send_request(OP_FOLD, 32'h7FFF_FFFF);
		send_request(OP_FOLD, 32'h8000_0000);
		send_request(OP_FOLD, -1);
		send_request(OP_UNUSED, 32'h7FFF_FFF0);
		send_request(OP_CONVERT, 1);
		send_request(OP_CONVERT, 32'h7FFF_FFFF);
		send_request(OP_CONVERT, 32'h4000_0000);
		send_request(OP_CONVERT, 32'h8000_0000);
		// A flat frame.
		send_request(OP_START, 32'h7FFF_FFFF);
		send_request(OP_FOLD, 1000);
		send_request(OP_CONVERT, 1000);
		// Quarter points of the range and samples beyond both ends.
		send_request(OP_START, 0);
		send_request(OP_FOLD, 32'h0001_0000);
		send_request(OP_FOLD, 32'h0005_0000);
		send_request(OP_CONVERT, 32'h0000_8000);
		send_request(OP_CONVERT, 32'h0002_0000);
		send_request(OP_CONVERT, 32'h0003_0000);
		send_request(OP_CONVERT, 32'h0006_0000);

		round = 0;
		while (requests_sent < ITEM_TARGET) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (round == 12) begin
				long_hold_burst();
			end else if ($urandom_range(0, 4) == 0) begin
				noise_burst();
			end else begin
				play_frame();
			end
			round++;
		end
		sample_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending != 0) begin
			$error("%0d expected pixels never arrived", pending);
		end
		$display("Sent %0d requests over %0d random frames plus directed cases.",
			requests_sent, frames_played);
		$display("Checked %0d pixels, %0d of them blank, with one %0d-cycle output hold-off.",
			pixels_checked, blank_pixels, LONG_HOLD);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: depth_min_max_jet_colormap_top.f
+incdir+design
design/dmm_pkg.sv
design/dmm_sample_if.sv
design/dmm_pixel_if.sv
design/dmm_div.sv
design/dmm_jet.sv
design/depth_min_max_jet_colormap_top.sv
bench/dmm_colormap_checker.sv
bench/tb_depth_min_max_jet_colormap_top.sv
